// ----- src/pcv_pkg.sv -----
// Package for the page checksum verifier: constants, defaults and the queue entry type.
// Used by pcv_front, pcv_queue, pcv_back and the core; depends on nothing.

package pcv_pkg;

  // Default geometry of a page
  localparam int unsigned PAGE_BYTES_DEF    = 4096;
  localparam int unsigned HEADER_BYTES_DEF  = 56;
  localparam int unsigned PAGE_ID_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  // Header field offsets, relative to the end of the page id
  localparam int unsigned OFS_ROWS_BASE     = 8;
  localparam int unsigned OFS_COLS_BASE     = 12;
  localparam int unsigned OFS_BITMAP_BASE   = 20;
  localparam int unsigned OFS_CHECKSUM_BASE = 48;

  // FNV-1a 32 constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Width of the hashed range end
  localparam int unsigned RANGE_W = 46;

  // One classified byte, handed from front to back
  typedef struct packed {
    logic [7:0]  page_byte;
    logic        hash_en;
    logic        last_byte;
    logic        range_short;
    logic [31:0] checksum;
  } item_t;

endpackage

// ----- src/pcv_in_if.sv -----
// Byte channel into the page checksum verifier: valid/ready with byte and last flag.
// Depends on nothing.

interface pcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       last_byte;

  modport source (output valid, output page_byte, output last_byte, input ready);
  modport sink   (input valid, input page_byte, input last_byte, output ready);
endinterface

// ----- src/pcv_out_if.sv -----
// Result channel of the page checksum verifier: valid/ready with the check result.
// Depends on nothing.

interface pcv_out_if;
  logic        valid;
  logic        ready;
  logic        checksum_ok;
  logic        checksum_disabled;
  logic        range_short;
  logic [31:0] computed_hash;
  logic [31:0] stored_checksum;

  modport source (output valid, output checksum_ok, output checksum_disabled,
                  output range_short, output computed_hash, output stored_checksum,
                  input ready);
  modport sink   (input valid, input checksum_ok, input checksum_disabled,
                  input range_short, input computed_hash, input stored_checksum,
                  output ready);
endinterface

// ----- src/pcv_front.sv -----
// Front end: accepts page bytes, tracks offset, captures header fields, works out the
// hashed range end and tags each byte for the back end. Depends on pcv_pkg, pcv_in_if.

module pcv_front #(
  parameter int unsigned PAGE_BYTES    = pcv_pkg::PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = pcv_pkg::HEADER_BYTES_DEF,
  parameter int unsigned PAGE_ID_BYTES = pcv_pkg::PAGE_ID_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcv_in_if.sink         in_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output pcv_pkg::item_t push_data_o
);

  localparam int unsigned POS_W        = $clog2(PAGE_BYTES + 1);
  localparam int unsigned RW           = pcv_pkg::RANGE_W;
  localparam int unsigned OFS_ROWS     = pcv_pkg::OFS_ROWS_BASE + PAGE_ID_BYTES;
  localparam int unsigned OFS_COLS     = pcv_pkg::OFS_COLS_BASE + PAGE_ID_BYTES;
  localparam int unsigned OFS_BITMAP   = pcv_pkg::OFS_BITMAP_BASE + PAGE_ID_BYTES;
  localparam int unsigned OFS_CHECKSUM = pcv_pkg::OFS_CHECKSUM_BASE + PAGE_ID_BYTES;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      rows_q, rows_d;
  logic [15:0]      cols_q, cols_d;
  logic [31:0]      bitmap_q, bitmap_d;
  logic [31:0]      chk_q, chk_d;
  logic [RW-1:0]    prod_q, prod_d;
  logic [RW-1:0]    range_end_q, range_end_d;

  logic             accept;
  logic             in_page;
  logic [31:0]      pos32;
  logic [RW-1:0]    pos_w;
  logic [RW-1:0]    pos_next_w;
  logic [POS_W-1:0] pos_inc;
  logic [29:0]      row_bytes;
  logic [RW:0]      range_sum;

  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  assign in_page = (32'(pos_q) < 32'(PAGE_BYTES));
  assign pos32   = 32'(pos_q);
  assign pos_w   = RW'(pos_q);
  assign pos_inc = in_page ? pos_q + POS_W'(1) : pos_q;
  assign pos_next_w = RW'(pos_inc);

  // Range end in two stages; the row, column and bitmap fields settle by offset 27, long before
  // hashing starts at the header end, so the lag of the stages never shows.
  assign row_bytes   = 30'((33'(rows_q) + 33'd7) >> 3);
  assign prod_d      = RW'(row_bytes) * RW'(cols_q);
  assign range_sum   = (RW+1)'(prod_q) + (RW+1)'(bitmap_q);
  assign range_end_d = range_sum[RW-1:0];

  // Header capture, offset count and tagging
  always_comb begin
    pos_d    = pos_q;
    rows_d   = rows_q;
    cols_d   = cols_q;
    bitmap_d = bitmap_q;
    chk_d    = chk_q;

    if (accept && in_page) begin
      for (int i = 0; i < 4; i++) begin
        if (pos32 == 32'(OFS_ROWS + i))     rows_d[8*i +: 8]   = in_i.page_byte;
        if (pos32 == 32'(OFS_BITMAP + i))   bitmap_d[8*i +: 8] = in_i.page_byte;
        if (pos32 == 32'(OFS_CHECKSUM + i)) chk_d[8*i +: 8]    = in_i.page_byte;
      end
      for (int i = 0; i < 2; i++) begin
        if (pos32 == 32'(OFS_COLS + i))     cols_d[8*i +: 8]   = in_i.page_byte;
      end
      pos_d = pos_inc;
    end

    push_data_o.page_byte   = in_i.page_byte;
    push_data_o.last_byte   = in_i.last_byte;
    push_data_o.hash_en     = in_page && (pos_w >= RW'(HEADER_BYTES)) &&
                              (pos_w < range_end_q);
    push_data_o.range_short = (pos_next_w < RW'(HEADER_BYTES)) ||
                              (pos_next_w < range_end_q);
    push_data_o.checksum    = chk_d;

    // Page done: back to the empty state for the next page
    if (accept && in_i.last_byte) begin
      pos_d    = '0;
      rows_d   = '0;
      cols_d   = '0;
      bitmap_d = '0;
      chk_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rows_q      <= '0;
      cols_q      <= '0;
      bitmap_q    <= '0;
      chk_q       <= '0;
      prod_q      <= '0;
      range_end_q <= '0;
    end else begin
      pos_q       <= pos_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      bitmap_q    <= bitmap_d;
      chk_q       <= chk_d;
      prod_q      <= prod_d;
      range_end_q <= range_end_d;
    end
  end

endmodule

// ----- src/pcv_queue.sv -----
// Short queue of classified bytes between the front and back ends.
// Depends on pcv_pkg.

module pcv_queue #(
  parameter int unsigned DEPTH = pcv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pcv_pkg::item_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pcv_pkg::item_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pcv_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    if (push && !pop) count_d = count_q + CNT_W'(1);
    if (pop && !push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- src/pcv_back.sv -----
// Back end: runs the FNV-1a 32 hash over tagged bytes and registers the page result.
// Depends on pcv_pkg and pcv_out_if.

module pcv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  pcv_pkg::item_t pop_data_i,
  pcv_out_if.source      res_o
);

  logic [31:0] hash_q, hash_d;
  logic [31:0] hash_upd;
  logic [31:0] hash_mix;
  logic        pop;
  logic        out_valid_q, out_valid_d;
  logic        ok_q, dis_q, short_q;
  logic [31:0] res_hash_q, chk_q;
  logic        dis_now, ok_now;

  // A last byte needs a free output register; others flow through
  assign pop_ready_o = !pop_data_i.last_byte || !out_valid_q || res_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // FNV-1a step
  assign hash_mix = hash_q ^ {24'd0, pop_data_i.page_byte};
  assign hash_upd = pop_data_i.hash_en ? hash_mix * pcv_pkg::FNV_PRIME : hash_q;

  assign dis_now = (pop_data_i.checksum == '0);
  assign ok_now  = dis_now || (!pop_data_i.range_short && hash_upd == pop_data_i.checksum);

  always_comb begin
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) out_valid_d = 1'b0;
    if (pop) begin
      hash_d = hash_upd;
      if (pop_data_i.last_byte) begin
        hash_d      = pcv_pkg::FNV_BASIS;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= pcv_pkg::FNV_BASIS;
      out_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop && pop_data_i.last_byte) begin
      ok_q       <= ok_now;
      dis_q      <= dis_now;
      short_q    <= pop_data_i.range_short;
      res_hash_q <= hash_upd;
      chk_q      <= pop_data_i.checksum;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.checksum_ok       = ok_q;
  assign res_o.checksum_disabled = dis_q;
  assign res_o.range_short       = short_q;
  assign res_o.computed_hash     = res_hash_q;
  assign res_o.stored_checksum   = chk_q;

endmodule

// ----- src/page_checksum_verifier_core.sv -----
// Page checksum verifier: FNV-1a 32 check of a page streamed one byte per transaction.
// Throughput one byte per cycle while the queue and output are not stalled; the FNV multiply is combinational.
// After the last byte is accepted it is written into the queue, and its pop sets the registered
// output valid in the back end; stalls on either side are absorbed by the queue.
// Reset clears offset, header fields, queue and output valid and loads the hash basis.
// Depends on pcv_pkg, pcv_in_if, pcv_out_if, pcv_front, pcv_queue, pcv_back.

module page_checksum_verifier_core #(
  parameter int unsigned PAGE_BYTES    = pcv_pkg::PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = pcv_pkg::HEADER_BYTES_DEF,
  parameter int unsigned PAGE_ID_BYTES = pcv_pkg::PAGE_ID_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH   = pcv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcv_in_if.sink    page_i,
  pcv_out_if.source result_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  pcv_pkg::item_t push_data, pop_data;

  // Offset tracking, header capture, byte tagging
  pcv_front #(
    .PAGE_BYTES    (PAGE_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .PAGE_ID_BYTES (PAGE_ID_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (page_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decoupling queue
  pcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Hash and result
  pcv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (result_o)
  );

endmodule
